### hdl/cmbsrt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cmbsrt_pkg
// Widths, the set size limit and the gap shrink arithmetic for the
// descending comb sort unit.
// ----------------------------------------------------------------------------
package cmbsrt_pkg;

  localparam int unsigned MAX_ITEMS = 64;
  localparam int unsigned ADDR_W    = $clog2(MAX_ITEMS);
  localparam int unsigned CNT_W     = $clog2(MAX_ITEMS + 1);

  localparam int unsigned KEY_W  = 32;
  localparam int unsigned TAG_W  = 16;
  localparam int unsigned DATA_W = KEY_W + TAG_W;

  // gap * 10 / 13 is done as a multiply by a rounded-up reciprocal.
  // The error stays below one unit for every gap up to 64.
  localparam int unsigned SHRINK_FRAC = 16;
  localparam int unsigned RECIP13     = (1 << SHRINK_FRAC) / 13 + 1;
  localparam logic [SHRINK_FRAC-1:0] SHRINK_MUL = SHRINK_FRAC'(10 * RECIP13);

  // Gaps that the comb sort 11 rule replaces, their replacement, and the floor.
  localparam logic [CNT_W-1:0] GAP_NINE   = CNT_W'(9);
  localparam logic [CNT_W-1:0] GAP_TEN    = CNT_W'(10);
  localparam logic [CNT_W-1:0] GAP_ELEVEN = CNT_W'(11);
  localparam logic [CNT_W-1:0] GAP_ONE    = CNT_W'(1);

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [KEY_W-1:0] key;
  } entry_t;

endpackage
`default_nettype wire

### hdl/comb_sort_descending_tagged_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// comb_sort_descending_tagged_unit
// Collects key/tag pairs and returns them in descending key order.
//
// Usage: pairs arrive on the slave stream (key in tdata[31:0], tag in
// tdata[47:32]); tlast closes the set, and so does the request that fills
// the 64th slot. The unit then stops taking requests and runs a comb sort
// (shrink 10/13, gaps of 9 and 10 become 11) over a single-port-write,
// dual-read store. A compare runs the read and compare states, plus the
// write-back on a swap; each pass adds a check state. One compare-swap at
// a time is the limit. The sorted pairs leave on the master stream, each
// read into the output register before it is offered, with tlast on the
// final pair. A stalled receiver holds the current result in its output
// register; nothing is dropped. After the last result is taken the unit
// is ready for a new set. Loading costs one cycle per pair. Reset empties
// the set and returns the unit to loading; the store is not cleared.
// ----------------------------------------------------------------------------
module comb_sort_descending_tagged_unit (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           s_axis_tvalid,
  output logic                          s_axis_tready,
  input  wire  [cmbsrt_pkg::DATA_W-1:0] s_axis_tdata,  // [31:0] sort_key, [47:32] item_tag
  input  wire                           s_axis_tlast,  // last_item
  output logic                          m_axis_tvalid,
  input  wire                           m_axis_tready,
  output logic [cmbsrt_pkg::DATA_W-1:0] m_axis_tdata,  // [31:0] out_key, [47:32] out_tag
  output logic                          m_axis_tlast   // out_last
);
  import cmbsrt_pkg::*;

  typedef enum logic [6:0] {
    ST_LOAD  = 7'b0000001,
    ST_CHECK = 7'b0000010,
    ST_READ  = 7'b0000100,
    ST_CMP   = 7'b0001000,
    ST_WRB   = 7'b0010000,
    ST_ORD   = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] gap;
  logic             swap;
  logic [CNT_W-1:0] idx_i;
  logic [CNT_W-1:0] idx_k;

  entry_t mem [MAX_ITEMS];
  entry_t rd_a;
  entry_t rd_b;

  logic                         in_fire;
  logic                         out_fire;
  logic                         set_done;
  logic [CNT_W-1:0]             count_inc;
  logic [CNT_W-1:0]             idx_j;
  logic                         in_range;
  logic                         do_swap;
  logic                         out_last;
  logic [CNT_W+SHRINK_FRAC-1:0] shrink_prod;
  logic [CNT_W-1:0]             gap_div;
  logic [CNT_W-1:0]             gap_next;

  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  entry_t             wr_data;

  assign s_axis_tready = (state == ST_LOAD);
  assign m_axis_tvalid = (state == ST_OUT);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_fire      = m_axis_tvalid && m_axis_tready;

  assign count_inc = count + CNT_W'(1);
  assign set_done  = s_axis_tlast || (count_inc == CNT_W'(MAX_ITEMS));
  assign idx_j     = idx_i + gap;
  assign in_range  = (idx_j < count);
  assign do_swap   = (rd_a.key < rd_b.key);
  assign out_last  = ((idx_k + CNT_W'(1)) == count);

  assign m_axis_tdata = rd_a;
  assign m_axis_tlast = out_last;

  // Next gap: gap * 10 / 13, then the comb sort 11 corrections.
  always_comb begin
    shrink_prod = (CNT_W + SHRINK_FRAC)'(gap) * (CNT_W + SHRINK_FRAC)'(SHRINK_MUL);
    gap_div     = shrink_prod[CNT_W+SHRINK_FRAC-1:SHRINK_FRAC];
    if ((gap_div == GAP_NINE) || (gap_div == GAP_TEN)) begin
      gap_next = GAP_ELEVEN;
    end else if (gap_div < GAP_ONE) begin
      gap_next = GAP_ONE;
    end else begin
      gap_next = gap_div;
    end
  end

  // Single store write port: loading, then the two halves of a swap.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count[ADDR_W-1:0];
    wr_data = entry_t'(s_axis_tdata);
    if (in_fire) begin
      wr_en = 1'b1;
    end else if ((state == ST_CMP) && do_swap) begin
      wr_en   = 1'b1;
      wr_addr = idx_i[ADDR_W-1:0];
      wr_data = rd_b;
    end else if (state == ST_WRB) begin
      wr_en   = 1'b1;
      wr_addr = idx_j[ADDR_W-1:0];
      wr_data = rd_a;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if ((state == ST_READ) && in_range) begin
      rd_a <= mem[idx_i[ADDR_W-1:0]];
      rd_b <= mem[idx_j[ADDR_W-1:0]];
    end else if (state == ST_ORD) begin
      rd_a <= mem[idx_k[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      count <= '0;
      gap   <= '0;
      swap  <= 1'b0;
      idx_i <= '0;
      idx_k <= '0;
    end else begin
      unique case (state)
        ST_LOAD: begin
          if (in_fire) begin
            count <= count_inc;
            if (set_done) begin
              gap   <= count_inc;
              swap  <= 1'b0;
              state <= ST_CHECK;
            end
          end
        end
        ST_CHECK: begin
          // A pass runs while the gap exceeds one or the last pass swapped.
          if ((gap > GAP_ONE) || swap) begin
            gap   <= gap_next;
            swap  <= 1'b0;
            idx_i <= '0;
            state <= ST_READ;
          end else begin
            idx_k <= '0;
            state <= ST_ORD;
          end
        end
        ST_READ: begin
          state <= in_range ? ST_CMP : ST_CHECK;
        end
        ST_CMP: begin
          if (do_swap) begin
            swap  <= 1'b1;
            state <= ST_WRB;
          end else begin
            idx_i <= idx_i + CNT_W'(1);
            state <= ST_READ;
          end
        end
        ST_WRB: begin
          idx_i <= idx_i + CNT_W'(1);
          state <= ST_READ;
        end
        ST_ORD: begin
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (out_fire) begin
            if (out_last) begin
              count <= '0;
              gap   <= '0;
              swap  <= 1'b0;
              state <= ST_LOAD;
            end else begin
              idx_k <= idx_k + CNT_W'(1);
              state <= ST_ORD;
            end
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // Loading and emitting never overlap.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid))
    else $error("request accepted while a result is pending");

  // A compare only ever sees two slots of the current set.
  a_cmp_in_set: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CMP) |-> (idx_j < count) && (gap != '0))
    else $error("compare outside the loaded set");

  // A swap write-back only follows a compare, with the swap flag already set.
  a_swap_flag: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WRB) |-> swap && $past(state == ST_CMP))
    else $error("second swap write without a swapping compare");

  // Emission stays within the set: the result index never passes the last slot.
  a_out_in_set: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (idx_k < count))
    else $error("result index beyond the set");
`endif

endmodule
`default_nettype wire

### tb/sv/comb_sort_order_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// comb_sort_order_checker
// Watches both streams of the comb sort unit. It collects each set of
// key/tag requests, sorts a private copy with the same comb sort pass
// schedule, and compares every emitted pair with the oldest prediction.
// ----------------------------------------------------------------------------
module comb_sort_order_checker (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           s_axis_tvalid,
  input  wire                           s_axis_tready,
  input  wire  [cmbsrt_pkg::DATA_W-1:0] s_axis_tdata,  // [31:0] sort_key, [47:32] item_tag
  input  wire                           s_axis_tlast,  // last_item
  input  wire                           m_axis_tvalid,
  input  wire                           m_axis_tready,
  input  wire  [cmbsrt_pkg::DATA_W-1:0] m_axis_tdata,  // [31:0] out_key, [47:32] out_tag
  input  wire                           m_axis_tlast,  // out_last
  output int                            fail_count,
  output int                            pending_count,
  output int                            results_checked,
  output int                            sets_closed
);
  import cmbsrt_pkg::*;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
    logic             last;
  } sorted_pair_t;

  logic [KEY_W-1:0] set_keys [MAX_ITEMS];
  logic [TAG_W-1:0] set_tags [MAX_ITEMS];
  int unsigned      set_len = 0;
  sorted_pair_t     sorted_q [$];
  int               fails = 0;
  int               results = 0;
  int               sets = 0;

  initial begin
    fail_count      = 0;
    pending_count   = 0;
    results_checked = 0;
    sets_closed     = 0;
  end

  function automatic int unsigned shrink_gap(int unsigned gap);
    int unsigned next;
    next = gap * 10 / 13;
    if (next == 9 || next == 10) next = 11;
    if (next < 1) next = 1;
    return next;
  endfunction

  // Sorts the collected set in place and queues the pairs in emit order.
  task automatic sort_set_descending();
    int unsigned      gap;
    int unsigned      i;
    bit               swapped;
    logic [KEY_W-1:0] k;
    logic [TAG_W-1:0] t;
    sorted_pair_t     p;
    gap = set_len;
    swapped = 1'b0;
    while (gap > 1 || swapped) begin
      gap = shrink_gap(gap);
      swapped = 1'b0;
      for (i = 0; i + gap < set_len; i++) begin
        if (set_keys[i] < set_keys[i + gap]) begin
          k = set_keys[i];
          t = set_tags[i];
          set_keys[i] = set_keys[i + gap];
          set_tags[i] = set_tags[i + gap];
          set_keys[i + gap] = k;
          set_tags[i + gap] = t;
          swapped = 1'b1;
        end
      end
    end
    for (i = 0; i < set_len; i++) begin
      p.key  = set_keys[i];
      p.tag  = set_tags[i];
      p.last = (i + 1 == set_len);
      sorted_q.push_back(p);
    end
  endtask

  always @(posedge clk) begin : watch
    sorted_pair_t want;
    if (rst) begin
      set_len = 0;
      sorted_q.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (sorted_q.size() == 0) begin
          $error("unexpected result: key %h tag %h last %b",
                 m_axis_tdata[KEY_W-1:0], m_axis_tdata[KEY_W +: TAG_W], m_axis_tlast);
          fails++;
        end else begin
          want = sorted_q.pop_front();
          if (m_axis_tdata[KEY_W-1:0] !== want.key) begin
            $error("out_key mismatch: expected %h, actual %h",
                   want.key, m_axis_tdata[KEY_W-1:0]);
            fails++;
          end
          if (m_axis_tdata[KEY_W +: TAG_W] !== want.tag) begin
            $error("out_tag mismatch: expected %h, actual %h",
                   want.tag, m_axis_tdata[KEY_W +: TAG_W]);
            fails++;
          end
          if (m_axis_tlast !== want.last) begin
            $error("out_last mismatch: expected %b, actual %b", want.last, m_axis_tlast);
            fails++;
          end
          results++;
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        set_keys[set_len] = s_axis_tdata[KEY_W-1:0];
        set_tags[set_len] = s_axis_tdata[KEY_W +: TAG_W];
        set_len++;
        // A full store closes the set even without tlast.
        if (s_axis_tlast || set_len == MAX_ITEMS) begin
          sort_set_descending();
          set_len = 0;
          sets++;
        end
      end
    end
    fail_count      <= fails;
    pending_count   <= sorted_q.size();
    results_checked <= results;
    sets_closed     <= sets;
  end

endmodule

### tb/sv/comb_sort_descending_tagged_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// comb_sort_descending_tagged_unit_tb
// Drives sets of key/tag requests into the comb sort unit: a few directed
// sets for ties, extremes and the sort gap rules, then random sets of 1 to
// 40 pairs and full stores under four flow control phases. The checker
// beside the unit predicts and compares every sorted result.
// ----------------------------------------------------------------------------
module comb_sort_descending_tagged_unit_tb;
  import cmbsrt_pkg::*;

  typedef enum int {MIX_WIDE, MIX_TIES, MIX_EDGES} key_mix_t;

  localparam int ITEM_BUDGET  = 370;
  localparam int PHASE_COUNT  = 4;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_axis_tvalid = 1'b0;
  logic [DATA_W-1:0] s_axis_tdata = '0;
  logic              s_axis_tlast = 1'b0;
  logic              m_axis_tready = 1'b0;
  wire               s_axis_tready;
  wire               m_axis_tvalid;
  wire  [DATA_W-1:0] m_axis_tdata;
  wire               m_axis_tlast;

  int fail_count;
  int pending_count;
  int results_checked;
  int sets_closed;
  int idle_pct = 0;
  int stall_pct = 0;
  int pairs_sent = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  comb_sort_descending_tagged_unit i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  comb_sort_order_checker i_sort_check (
    .clk             (clk),
    .rst             (rst),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .s_axis_tlast    (s_axis_tlast),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .m_axis_tlast    (m_axis_tlast),
    .fail_count      (fail_count),
    .pending_count   (pending_count),
    .results_checked (results_checked),
    .sets_closed     (sets_closed)
  );

  always @(posedge clk) m_axis_tready <= ($urandom_range(99) >= stall_pct);

  // Called at a rising edge; returns at the edge where the request is taken.
  task automatic send_pair(input logic [KEY_W-1:0] key, input logic [TAG_W-1:0] tag,
                           input logic last);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {tag, key};
    s_axis_tlast  <= last;
    do @(posedge clk); while (!s_axis_tready);
    pairs_sent++;
  endtask

  function automatic logic [KEY_W-1:0] pick_key(key_mix_t mix);
    case (mix)
      MIX_TIES:  return KEY_W'($urandom_range(7)) << 16;
      MIX_EDGES: begin
        case ($urandom_range(5))
          0:       return '0;
          1:       return '1;
          2:       return 32'h8000_0000;
          3:       return 32'h0000_ffff;
          4:       return 32'h0001_0000;
          default: return $urandom();
        endcase
      end
      default:   return $urandom();
    endcase
  endfunction

  task automatic send_random_set();
    int unsigned len;
    int unsigned i;
    int unsigned roll;
    key_mix_t    mix;
    bit          close_full;
    roll = $urandom_range(99);
    if (roll < 8) len = MAX_ITEMS;
    else if (roll < 25) len = $urandom_range(40, 13);
    else len = $urandom_range(12, 1);
    mix = key_mix_t'($urandom_range(MIX_EDGES, MIX_WIDE));
    // Full sets sometimes end without tlast, relying on the store limit.
    close_full = bit'($urandom_range(1));
    for (i = 0; i < len; i++)
      send_pair(pick_key(mix), TAG_W'($urandom_range(16'hffff)),
                (i + 1 == len) && (len < MAX_ITEMS || close_full));
  endtask

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int i;
    int phase;
    int directed;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Single pair, a tied pair, extremes, an all-equal set, and a 13-pair
    // ascending set that goes through the gap 10 to 11 rule.
    send_pair(32'hffff_ffff, 16'hffff, 1'b1);
    send_pair(32'd5, 16'h0001, 1'b0);
    send_pair(32'd5, 16'h0002, 1'b1);
    send_pair(32'h0000_0000, 16'h0000, 1'b0);
    send_pair(32'hffff_ffff, 16'hffff, 1'b0);
    send_pair(32'h8000_0000, 16'h8000, 1'b1);
    for (i = 0; i < 5; i++) send_pair(32'h0001_0000, TAG_W'(i + 'h100), i == 4);
    for (i = 0; i < 13; i++) send_pair(KEY_W'(i / 2) << 16, TAG_W'(i), i == 12);
    directed = pairs_sent;

    for (phase = 0; phase < PHASE_COUNT; phase++) begin
      case (phase)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 73; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 73; end
        default: begin idle_pct = 16; stall_pct = 16; end
      endcase
      while (pairs_sent < directed + (phase + 1) * (ITEM_BUDGET - directed) / PHASE_COUNT)
        send_random_set();
    end
    s_axis_tvalid <= 1'b0;

    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    $display("Sent %0d pairs in %0d sets; %0d sorted results compared.",
             pairs_sent, sets_closed, results_checked);
    $display("Phases: free flow, sender idling, receiver stalling, and both at once.");
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
